FILE: src/fdfp_pkg.sv
// ----------------------------------------------------------------------------
// fdfp_pkg
// Shared constants, result word type and helpers for the framed decimal
// field parser.
// ----------------------------------------------------------------------------
package fdfp_pkg;

    // Frame geometry and fixed-point scale
    localparam int MAX_FIELDS      = 16;
    localparam int FRACTION_PLACES = 6;

    // Widths
    localparam int BYTE_W   = 8;
    localparam int VALUE_W  = 48;
    localparam int INDEX_W  = 4;
    localparam int CFG_W    = 5;
    localparam int COUNT_W  = $clog2(MAX_FIELDS + 2);
    localparam int FRAC_W   = $clog2(FRACTION_PLACES + 1);
    localparam int WEIGHT_W = 30;               // holds 10^9
    localparam int SUM_W    = VALUE_W + 4;      // mag*10 + digit*scale headroom

    // Magnitude caps (positive and negative)
    localparam logic [SUM_W-1:0] POS_CAP = SUM_W'((64'd1 << (VALUE_W - 1)) - 64'd1);
    localparam logic [SUM_W-1:0] NEG_CAP = SUM_W'(64'd1 << (VALUE_W - 1));

    // Highest index that fits the index field
    localparam logic [COUNT_W-1:0] INDEX_MAX = COUNT_W'((1 << INDEX_W) - 1);

    // Character codes
    localparam logic [BYTE_W-1:0] CH_OPEN   = 8'h26;  // '&'
    localparam logic [BYTE_W-1:0] CH_CLOSE  = 8'h2A;  // '*'
    localparam logic [BYTE_W-1:0] CH_TOGGLE = 8'h21;  // '!'
    localparam logic [BYTE_W-1:0] CH_POINT  = 8'h2E;  // '.'
    localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;  // '-'
    localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;  // '+'
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;  // '0'
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;  // '9'

    // Result kinds
    localparam logic KIND_FIELD = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    // One result word
    typedef struct packed {
        logic                      kind;
        logic [INDEX_W-1:0]        index;
        logic signed [VALUE_W-1:0] value;
        logic                      ok;
        logic                      sat;
    } result_t;

    // Decimal powers 10^0 .. 10^9
    function automatic logic [WEIGHT_W-1:0] pow10(input logic [3:0] n);
        logic [WEIGHT_W-1:0] p;
        begin
            case (n)
                4'd1:    p = WEIGHT_W'(10);
                4'd2:    p = WEIGHT_W'(100);
                4'd3:    p = WEIGHT_W'(1000);
                4'd4:    p = WEIGHT_W'(10000);
                4'd5:    p = WEIGHT_W'(100000);
                4'd6:    p = WEIGHT_W'(1000000);
                4'd7:    p = WEIGHT_W'(10000000);
                4'd8:    p = WEIGHT_W'(100000000);
                4'd9:    p = WEIGHT_W'(1000000000);
                default: p = WEIGHT_W'(1);
            endcase
            return p;
        end
    endfunction

    // Full fixed-point scale, one integer unit
    localparam logic [WEIGHT_W-1:0] SCALE = WEIGHT_W'(64'd10 ** FRACTION_PLACES);

endpackage

FILE: src/framed_decimal_field_parser.sv
// ----------------------------------------------------------------------------
// framed_decimal_field_parser
// Byte-stream parser for '&'-opened, '*'-closed frames of '!'-delimited
// decimal fields, each returned as a signed value in millionths.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while in_stall is low; each byte
// updates the running field state, where the value is kept already scaled to
// millionths (an integer digit does one multiply-by-ten and add, a fraction
// digit adds a digit times its place weight), so closing a field needs only a
// negate. A result is built from the byte that causes it ('!' closing a field,
// or '*') and registered; a two-entry output buffer lets the input keep flowing
// while one result waits, and in_stall rises only when both entries are full.
// expected_count is written through cfg_write_en/cfg_write_data; the user must
// write it only while the stream is idle, which the block does not enforce.
module framed_decimal_field_parser
(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_write_en,
    input  logic [fdfp_pkg::CFG_W-1:0]        cfg_write_data,
    // byte input
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [fdfp_pkg::BYTE_W-1:0]       rx_byte,
    // result output
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              result_kind,
    output logic [fdfp_pkg::INDEX_W-1:0]      field_index,
    output logic signed [fdfp_pkg::VALUE_W-1:0] field_value,
    output logic                              frame_ok,
    output logic                              value_saturated
);

    localparam int SUM_W   = fdfp_pkg::SUM_W;
    localparam int VALUE_W = fdfp_pkg::VALUE_W;
    localparam int COUNT_W = fdfp_pkg::COUNT_W;
    localparam int FRAC_W  = fdfp_pkg::FRAC_W;

    // Configuration and parser state
    logic [fdfp_pkg::CFG_W-1:0] expected_count_reg;
    logic                       in_frame_reg,  in_frame_next;
    logic                       in_field_reg,  in_field_next;
    logic                       neg_reg,       neg_next;
    logic                       point_reg,     point_next;
    logic                       stopped_reg,   stopped_next;
    logic                       any_char_reg,  any_char_next;
    logic                       ovf_reg,       ovf_next;
    logic [VALUE_W-1:0]         mag_reg,       mag_next;
    logic [FRAC_W-1:0]          frac_reg,      frac_next;
    logic [COUNT_W-1:0]         count_reg,     count_next;

    // Output buffer: main register plus skid entry
    logic                       out_valid_reg, skid_valid_reg;
    fdfp_pkg::result_t          out_data_reg,  skid_data_reg;

    logic                       in_accept;
    logic                       out_take;
    logic                       new_valid;
    fdfp_pkg::result_t          new_res;
    logic                       clear_field;

    // Arithmetic on the scaled magnitude
    logic [3:0]                     digit;
    logic                           is_digit;
    logic [SUM_W-1:0]               cap;
    logic [SUM_W-1:0]               int_sum;
    logic [SUM_W-1:0]               frac_sum;
    logic [fdfp_pkg::WEIGHT_W-1:0]  frac_weight;
    logic [VALUE_W-1:0]             signed_mag;
    logic [fdfp_pkg::INDEX_W-1:0]   count_index;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;

    assign digit    = rx_byte[3:0];
    assign is_digit = (rx_byte >= fdfp_pkg::CH_ZERO) && (rx_byte <= fdfp_pkg::CH_NINE);
    assign cap      = neg_reg ? fdfp_pkg::NEG_CAP : fdfp_pkg::POS_CAP;

    // integer digit: mag*10 + digit*10^FRACTION_PLACES
    assign int_sum = (SUM_W'(mag_reg) << 3) + (SUM_W'(mag_reg) << 1)
                   + SUM_W'(SUM_W'(digit) * SUM_W'(fdfp_pkg::SCALE));

    // fraction digit: mag + digit*10^(places-1-frac)
    assign frac_weight = fdfp_pkg::pow10(4'(fdfp_pkg::FRACTION_PLACES - 1) - 4'(frac_reg));
    assign frac_sum    = SUM_W'(mag_reg)
                       + SUM_W'(SUM_W'(digit) * SUM_W'(frac_weight));

    assign signed_mag  = neg_reg ? (VALUE_W'(0) - mag_reg) : mag_reg;
    assign count_index = (count_reg > fdfp_pkg::INDEX_MAX)
                       ? fdfp_pkg::INDEX_W'(fdfp_pkg::INDEX_MAX)
                       : fdfp_pkg::INDEX_W'(count_reg);

    // Per-byte state update and result build
    always_comb
    begin
        in_frame_next = in_frame_reg;
        in_field_next = in_field_reg;
        neg_next      = neg_reg;
        point_next    = point_reg;
        stopped_next  = stopped_reg;
        any_char_next = any_char_reg;
        ovf_next      = ovf_reg;
        mag_next      = mag_reg;
        frac_next     = frac_reg;
        count_next    = count_reg;
        clear_field   = 1'b0;
        new_valid     = 1'b0;
        new_res       = '0;

        if (in_accept)
        begin
            if (!in_frame_reg)
            begin
                if (rx_byte == fdfp_pkg::CH_OPEN)
                begin
                    in_frame_next = 1'b1;
                    in_field_next = 1'b0;
                    count_next    = '0;
                    clear_field   = 1'b1;
                end
            end
            else if (rx_byte == fdfp_pkg::CH_CLOSE)
            begin
                // frame end; an open field is dropped
                new_valid     = 1'b1;
                new_res.kind  = fdfp_pkg::KIND_FRAME;
                new_res.index = count_index;
                new_res.value = VALUE_W'(count_reg);
                new_res.sat   = count_reg > COUNT_W'(fdfp_pkg::MAX_FIELDS);
                new_res.ok    = (count_reg <= COUNT_W'(fdfp_pkg::MAX_FIELDS))
                             && (count_reg == COUNT_W'(expected_count_reg));
                in_frame_next = 1'b0;
                in_field_next = 1'b0;
                clear_field   = 1'b1;
            end
            else if (rx_byte == fdfp_pkg::CH_TOGGLE)
            begin
                if (in_field_reg)
                begin
                    // field close
                    new_valid     = 1'b1;
                    new_res.kind  = fdfp_pkg::KIND_FIELD;
                    new_res.index = count_index;
                    new_res.value = signed_mag;
                    new_res.ok    = 1'b0;
                    new_res.sat   = ovf_reg
                                 || (count_reg >= COUNT_W'(fdfp_pkg::MAX_FIELDS));
                    if (count_reg <= COUNT_W'(fdfp_pkg::MAX_FIELDS))
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                    in_field_next = 1'b0;
                end
                else
                begin
                    in_field_next = 1'b1;
                end
                clear_field = 1'b1;
            end
            else if (in_field_reg)
            begin
                // character inside a field
                any_char_next = 1'b1;
                if (!stopped_reg)
                begin
                    if (is_digit)
                    begin
                        if (!point_reg)
                        begin
                            if (int_sum > cap)
                            begin
                                mag_next = VALUE_W'(cap);
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                mag_next = VALUE_W'(int_sum);
                            end
                        end
                        else if (frac_reg < FRAC_W'(fdfp_pkg::FRACTION_PLACES))
                        begin
                            if (frac_sum > cap)
                            begin
                                mag_next = VALUE_W'(cap);
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                mag_next = VALUE_W'(frac_sum);
                            end
                            frac_next = frac_reg + FRAC_W'(1);
                        end
                    end
                    else if ((rx_byte == fdfp_pkg::CH_POINT) && !point_reg)
                    begin
                        point_next = 1'b1;
                    end
                    else if (!any_char_reg && ((rx_byte == fdfp_pkg::CH_MINUS)
                                            || (rx_byte == fdfp_pkg::CH_PLUS)))
                    begin
                        neg_next = (rx_byte == fdfp_pkg::CH_MINUS);
                    end
                    else
                    begin
                        stopped_next = 1'b1;
                    end
                end
            end
        end

        // fresh field state
        if (clear_field)
        begin
            neg_next      = 1'b0;
            point_next    = 1'b0;
            stopped_next  = 1'b0;
            any_char_next = 1'b0;
            ovf_next      = 1'b0;
            mag_next      = '0;
            frac_next     = '0;
        end
    end

    // Control and parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_count_reg <= '0;
            in_frame_reg       <= 1'b0;
            in_field_reg       <= 1'b0;
            neg_reg            <= 1'b0;
            point_reg          <= 1'b0;
            stopped_reg        <= 1'b0;
            any_char_reg       <= 1'b0;
            ovf_reg            <= 1'b0;
            mag_reg            <= '0;
            frac_reg           <= '0;
            count_reg          <= '0;
            out_valid_reg      <= 1'b0;
            skid_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                expected_count_reg <= cfg_write_data;
            end
            in_frame_reg <= in_frame_next;
            in_field_reg <= in_field_next;
            neg_reg      <= neg_next;
            point_reg    <= point_next;
            stopped_reg  <= stopped_next;
            any_char_reg <= any_char_next;
            ovf_reg      <= ovf_next;
            mag_reg      <= mag_next;
            frac_reg     <= frac_next;
            count_reg    <= count_next;

            // output buffer occupancy
            if (!out_valid_reg || out_take)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= new_valid;
                end
            end
            else if (new_valid)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Output buffer payload
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (new_valid)
            begin
                out_data_reg <= new_res;
            end
        end
        else if (new_valid)
        begin
            skid_data_reg <= new_res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign result_kind     = out_data_reg.kind;
    assign field_index     = out_data_reg.index;
    assign field_value     = out_data_reg.value;
    assign frame_ok        = out_data_reg.ok;
    assign value_saturated = out_data_reg.sat;

endmodule

FILE: src/fdfp_checker.sv
// ----------------------------------------------------------------------------
// fdfp_checker
// Port-level checks for the framed decimal field parser, bound to the top.
// ----------------------------------------------------------------------------
module fdfp_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic                                result_kind,
    input logic signed [fdfp_pkg::VALUE_W-1:0] field_value,
    input logic                                frame_ok,
    input logic                                value_saturated
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // input backpressure only with a result already waiting
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    // field results never report frame ok
    a_field_not_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == fdfp_pkg::KIND_FIELD) |-> !frame_ok)
        else $error("field result with frame_ok set");

    // frame end: count is small, and an overfull frame is never ok
    a_frame_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == fdfp_pkg::KIND_FRAME)
        |-> (field_value[fdfp_pkg::VALUE_W-1:fdfp_pkg::COUNT_W] == '0)
            && !(frame_ok && value_saturated))
        else $error("bad frame end result");

endmodule

bind framed_decimal_field_parser fdfp_checker u_fdfp_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .result_kind     (result_kind),
    .field_value     (field_value),
    .frame_ok        (frame_ok),
    .value_saturated (value_saturated)
);
